@@ design/acfpe_pkg.sv @@
// Shared types, codes and frame constants for the IR frame pulse encoder.
package acfpe_pkg;

  localparam int FRAME_BYTES = 13;
  localparam logic [6:0] DATA_BITS = 7'd104;

  // One frame, byte 0 in the lowest lane
  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  // Per-cell control, common to every cell of the chain
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  // Climate mode codes
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_COOL = 2'd1;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ST_NO_FRAME    = 2'd2;

  // Fan request codes and applied fan codes
  localparam logic [2:0] FAN_REQ_MED  = 3'd2;
  localparam logic [2:0] FAN_REQ_HIGH = 3'd3;
  localparam logic [1:0] FAN_LOW  = 2'd1;
  localparam logic [1:0] FAN_MED  = 2'd2;
  localparam logic [1:0] FAN_HIGH = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_HEADER_MARK  = 3'd0;
  localparam logic [2:0] REG_HEADER_SPACE = 3'd1;
  localparam logic [2:0] REG_BIT_MARK     = 3'd2;
  localparam logic [2:0] REG_ZERO_SPACE   = 3'd3;
  localparam logic [2:0] REG_ONE_SPACE    = 3'd4;
  localparam logic [2:0] REG_FINAL_SPACE  = 3'd5;

  // Register reset values
  localparam logic [15:0] HEADER_MARK_RST  = 16'd9132;
  localparam logic [15:0] HEADER_SPACE_RST = 16'd4579;
  localparam logic [15:0] BIT_MARK_RST     = 16'd553;
  localparam logic [15:0] ZERO_SPACE_RST   = 16'd579;
  localparam logic [15:0] ONE_SPACE_RST    = 16'd1737;
  localparam logic [15:0] FINAL_SPACE_RST  = 16'd25316;

  // Temperature range
  localparam logic signed [7:0] TEMP_MIN = 8'sd16;
  localparam logic signed [7:0] TEMP_MAX = 8'sd32;

  // Fixed frame bytes
  localparam logic [7:0] B_PREAMBLE  = 8'hC3;
  localparam logic [7:0] B_TEMP_BASE = 8'h47;
  localparam logic [7:0] B_MODE      = 8'hE0;
  localparam logic [7:0] B_FAN_HIGH  = 8'h20;
  localparam logic [7:0] B_FAN_MED   = 8'h40;
  localparam logic [7:0] B_FAN_LOW   = 8'h60;
  localparam logic [7:0] B_FLAG      = 8'h20;

  // Off frame, byte 12 first
  localparam frame_t OFF_FRAME = {
    8'h87, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h60, 8'h00, 8'hE0, 8'h7F, 8'hC3
  };

endpackage

@@ design/acfpe_cell.sv @@
// One byte cell of the frame shift chain.
module acfpe_cell (
  input  logic                clk,
  input  acfpe_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          load_data,
  input  logic                shift_in,
  output logic                shift_out
);
  import acfpe_pkg::*;

  logic [7:0] data;

  // Parallel load on start, one bit toward the head on each pulse
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_data;
    end else if (ctrl.shift) begin
      data <= {shift_in, data[7:1]};
    end
  end

  assign shift_out = data[0];

endmodule

@@ design/acfpe_frame_build.sv @@
// Frame byte builder: off frame or cool frame with clamped temp, fan and checksum.
module acfpe_frame_build (
  input  logic                  [1:0] climate_mode,
  input  logic signed           [7:0] target_temp,
  input  logic                  [2:0] fan_request,
  output acfpe_pkg::frame_t           frame,
  output logic                  [5:0] applied_temp,
  output logic                  [1:0] applied_fan
);
  import acfpe_pkg::*;

  logic signed [7:0] temp_clamp;
  logic [4:0]        temp_off;
  logic [7:0]        temp_byte;
  logic [7:0]        fan_byte;
  logic [7:0]        checksum;
  frame_t            cool_frame;

  // Clamp to the supported range
  always_comb begin
    if (target_temp < TEMP_MIN) begin
      temp_clamp = TEMP_MIN;
    end else if (target_temp > TEMP_MAX) begin
      temp_clamp = TEMP_MAX;
    end else begin
      temp_clamp = target_temp;
    end
  end

  assign temp_off  = 5'(temp_clamp - TEMP_MIN);
  assign temp_byte = B_TEMP_BASE + {temp_off, 3'b000};

  // Fan mapping, unknown requests run low
  always_comb begin
    case (fan_request)
      FAN_REQ_HIGH: begin
        fan_byte    = B_FAN_HIGH;
        applied_fan = FAN_HIGH;
      end
      FAN_REQ_MED: begin
        fan_byte    = B_FAN_MED;
        applied_fan = FAN_MED;
      end
      default: begin
        fan_byte    = B_FAN_LOW;
        applied_fan = FAN_LOW;
      end
    endcase
  end

  assign applied_temp = temp_clamp[5:0];

  // 8-bit sum of the first twelve bytes
  assign checksum = B_PREAMBLE + temp_byte + B_MODE + fan_byte + B_FLAG + B_FLAG;

  always_comb begin
    cool_frame     = '0;
    cool_frame[0]  = B_PREAMBLE;
    cool_frame[1]  = temp_byte;
    cool_frame[2]  = B_MODE;
    cool_frame[4]  = fan_byte;
    cool_frame[6]  = B_FLAG;
    cool_frame[9]  = B_FLAG;
    cool_frame[12] = checksum;
  end

  assign frame = (climate_mode == MODE_OFF) ? OFF_FRAME : cool_frame;

endmodule

@@ design/ac_ir_frame_pulse_encoder.sv @@
// Top level: IR frame pulse encoder with a 13-cell frame shift chain.
// A result is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle while the result stream is not stalled; the output register frees as it is taken.
// Each data pulse request shifts the whole cell chain by one bit in that cycle; the final pulse does not shift it.
// Reset clears frame control and output valid, loads register defaults, holds off requests.
// Frame cells hold no reset value and are loaded by every good start.
module ac_ir_frame_pulse_encoder (
  input  logic        clk,
  input  logic        rst,
  // Config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // climate_mode[1:0], target_temp[9:2], fan_request[12:10]
  input  logic [0:0]  s_tuser,  // cmd[0]
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // mark_us[15:0], space_us[31:16], applied_temp[37:32],
                                // applied_fan[39:38]
  output logic [2:0]  m_tuser,  // pulse_valid[0], status[2:1]
  output logic        m_tlast   // last_pulse
);
  import acfpe_pkg::*;

  logic [15:0] header_mark_us;
  logic [15:0] header_space_us;
  logic [15:0] bit_mark_us;
  logic [15:0] zero_space_us;
  logic [15:0] one_space_us;
  logic [15:0] final_space_us;

  logic [6:0]  pulse_position;
  logic        frame_active;

  logic              in_fire;
  logic              cmd;
  logic [1:0]        climate_mode;
  logic signed [7:0] target_temp;
  logic [2:0]        fan_request;

  frame_t     build_frame;
  logic [5:0] build_temp;
  logic [1:0] build_fan;

  cell_ctrl_t          ctrl;
  logic [FRAME_BYTES-1:0] cell_lsb;

  logic        pulse_valid_next;
  logic [15:0] mark_next;
  logic [15:0] space_next;
  logic        last_next;
  logic [1:0]  status_next;
  logic [5:0]  temp_next;
  logic [1:0]  fan_next;
  logic [6:0]  pulse_position_next;
  logic        frame_active_next;

  assign cmd          = s_tuser[0];
  assign climate_mode = s_tdata[1:0];
  assign target_temp  = s_tdata[9:2];
  assign fan_request  = s_tdata[12:10];

  assign cfg_ready = !rst;
  assign s_tready  = !rst && (!m_tvalid || m_tready);
  assign in_fire   = s_tvalid && s_tready;

  // Duration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_mark_us  <= HEADER_MARK_RST;
      header_space_us <= HEADER_SPACE_RST;
      bit_mark_us     <= BIT_MARK_RST;
      zero_space_us   <= ZERO_SPACE_RST;
      one_space_us    <= ONE_SPACE_RST;
      final_space_us  <= FINAL_SPACE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEADER_MARK:  header_mark_us  <= cfg_data;
        REG_HEADER_SPACE: header_space_us <= cfg_data;
        REG_BIT_MARK:     bit_mark_us     <= cfg_data;
        REG_ZERO_SPACE:   zero_space_us   <= cfg_data;
        REG_ONE_SPACE:    one_space_us    <= cfg_data;
        REG_FINAL_SPACE:  final_space_us  <= cfg_data;
        default: ;
      endcase
    end
  end

  acfpe_frame_build u_build (
    .climate_mode (climate_mode),
    .target_temp  (target_temp),
    .fan_request  (fan_request),
    .frame        (build_frame),
    .applied_temp (build_temp),
    .applied_fan  (build_fan)
  );

  // Frame chain: cell 0 holds the bit being sent in its LSB
  for (genvar g = 0; g < FRAME_BYTES; g++) begin : g_cell
    logic shift_in;
    if (g == FRAME_BYTES - 1) begin : g_tail
      assign shift_in = 1'b0;
    end else begin : g_link
      assign shift_in = cell_lsb[g+1];
    end
    acfpe_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_data (build_frame[g]),
      .shift_in  (shift_in),
      .shift_out (cell_lsb[g])
    );
  end

  // Request decode
  always_comb begin
    ctrl                = '0;
    pulse_valid_next    = 1'b0;
    mark_next           = '0;
    space_next          = '0;
    last_next           = 1'b0;
    status_next         = ST_OK;
    temp_next           = '0;
    fan_next            = '0;
    pulse_position_next = pulse_position;
    frame_active_next   = frame_active;
    if (cmd == CMD_START) begin
      pulse_position_next = '0;
      if (climate_mode == MODE_OFF || climate_mode == MODE_COOL) begin
        ctrl.load         = in_fire;
        frame_active_next = 1'b1;
        pulse_valid_next  = 1'b1;
        mark_next         = header_mark_us;
        space_next        = header_space_us;
        if (climate_mode == MODE_COOL) begin
          temp_next = build_temp;
          fan_next  = build_fan;
        end
      end else begin
        frame_active_next = 1'b0;
        status_next       = ST_UNSUPPORTED;
      end
    end else if (!frame_active) begin
      status_next = ST_NO_FRAME;
    end else begin
      pulse_valid_next = 1'b1;
      mark_next        = bit_mark_us;
      if (pulse_position < DATA_BITS) begin
        ctrl.shift          = in_fire;
        space_next          = cell_lsb[0] ? one_space_us : zero_space_us;
        pulse_position_next = pulse_position + 7'd1;
      end else begin
        space_next          = final_space_us;
        last_next           = 1'b1;
        frame_active_next   = 1'b0;
        pulse_position_next = '0;
      end
    end
  end

  // Frame control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_position <= '0;
      frame_active   <= 1'b0;
    end else if (in_fire) begin
      pulse_position <= pulse_position_next;
      frame_active   <= frame_active_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tdata <= {fan_next, temp_next, space_next, mark_next};
      m_tuser <= {status_next, pulse_valid_next};
      m_tlast <= last_next;
    end
  end

  // Position stays within the frame
  assert property (@(posedge clk) disable iff (rst) pulse_position <= DATA_BITS)
    else $error("pulse position beyond frame");

  // Idle frame control sits at position zero
  assert property (@(posedge clk) disable iff (rst) !frame_active |-> pulse_position == '0)
    else $error("position nonzero with no frame");

  // A last pulse is a valid pulse with ok status
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0] && m_tuser[2:1] == ST_OK)
    else $error("last pulse without a valid pulse");

  // An error status never carries a pulse
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:1] != ST_OK |-> !m_tuser[0])
    else $error("pulse with error status");

  // Accepting the final pulse ends the frame
  assert property (@(posedge clk) disable iff (rst)
    in_fire && cmd == CMD_NEXT && frame_active && pulse_position == DATA_BITS
    |=> !frame_active)
    else $error("frame still active after final pulse");

endmodule
